// ===== design/framed_packet_receiver_assert.svh =====
// Assertion macros shared by the receiver's checker.
// Depends on nothing; take it in by `include.
`ifndef FRAMED_PACKET_RECEIVER_ASSERT_SVH
`define FRAMED_PACKET_RECEIVER_ASSERT_SVH

// Check prop at every clock edge outside reset.
`define FPR_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check prop at every clock edge, reset included.
`define FPR_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/fpr_pkg.sv =====
// Shared types and constants of the framed packet receiver.
// Status codes, register indexes, reset values and the CRC8 step.
package fpr_pkg;

  typedef enum logic [2:0] {
    ST_CONTINUE = 3'd0,
    ST_NEW      = 3'd1,
    ST_CRC_ERR  = 3'd2,
    ST_LEN_ERR  = 3'd3,
    ST_STOP_ERR = 3'd4,
    ST_STALE    = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    REG_TIMEOUT = 2'd0,
    REG_START   = 2'd1,
    REG_STOP    = 2'd2,
    REG_NONE    = 2'd3
  } reg_idx_e;

  localparam logic [31:0] TIMEOUT_RESET = 32'd50;
  localparam logic [7:0]  START_RESET   = 8'd126;
  localparam logic [7:0]  STOP_RESET    = 8'd129;
  localparam logic [7:0]  CRC_POLY      = 8'h9B;

  // One byte of CRC8, MSB first.
  function automatic logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ===== design/fpr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module fpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 254
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== design/framed_packet_receiver.sv =====
// Framed packet receiver: start/id/overhead/length/payload/CRC8/stop parser
// with on-the-fly unstuffing. Uses fpr_pkg and fpr_ram.
//
// Usage: one beat on the input channel carries either a line byte
// (req_type_i = 0) with its millisecond timestamp, or a read of a stored
// payload byte (req_type_i = 1, read_index_i). Every accepted beat gives
// exactly one result beat: status, id of the last good packet, its length
// (0 after a line beat that does not end a good packet), and the read
// byte (0 for line bytes). The result is registered: it is valid in the
// cycle after the input beat is accepted. One beat per cycle is taken while
// results are taken; the parser, the CRC8 step and the payload store (one
// write port, one registered read port) all finish a beat as it is accepted.
// When the result is not taken, the result register holds and in_ready_o
// drops until it is taken; in_ready_o follows out_ready_i in that cycle.
// Reset clears the parser to seeking start, disarms the timer, restores
// timeout 50 ms, start byte 126 and stop byte 129. The payload store is not
// cleared; only written bytes may be read back.
// Registers over APB: timeout at 0x0, start byte at 0x4, stop byte at 0x8.
module framed_packet_receiver #(
  parameter int MAX_PAYLOAD = 254
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               req_type_i,
  input  logic [7:0]         data_byte_i,
  input  logic [31:0]        now_ms_i,
  input  logic [7:0]         read_index_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output fpr_pkg::status_e   status_o,
  output logic [7:0]         good_id_o,
  output logic [7:0]         packet_len_o,
  output logic [7:0]         read_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import fpr_pkg::*;

  localparam int          AW      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [7:0]  MaxPay8 = 8'(MAX_PAYLOAD);
  localparam logic [8:0]  MaxPay9 = 9'(MAX_PAYLOAD);

  typedef enum logic [2:0] {
    PH_START    = 3'd0,
    PH_ID       = 3'd1,
    PH_OVERHEAD = 3'd2,
    PH_LEN      = 3'd3,
    PH_PAYLOAD  = 3'd4,
    PH_CRC      = 3'd5,
    PH_STOP     = 3'd6
  } phase_e;

  // Configuration registers.
  logic [31:0] timeout_q;
  logic [7:0]  start_byte_q;
  logic [7:0]  stop_byte_q;
  reg_idx_e    cfg_idx;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q    <= TIMEOUT_RESET;
      start_byte_q <= START_RESET;
      stop_byte_q  <= STOP_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_TIMEOUT: timeout_q    <= pwdata;
        REG_START:   start_byte_q <= pwdata[7:0];
        REG_STOP:    stop_byte_q  <= pwdata[7:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_TIMEOUT: prdata = timeout_q;
      REG_START:   prdata = {24'd0, start_byte_q};
      REG_STOP:    prdata = {24'd0, stop_byte_q};
      default:     prdata = '0;
    endcase
  end

  // Parser state.
  phase_e      phase_q, phase_d;
  logic [7:0]  frame_id_q, frame_id_d;
  logic [7:0]  expected_len_q, expected_len_d;
  logic [7:0]  byte_count_q, byte_count_d;
  logic [7:0]  crc_q, crc_d;
  logic [7:0]  unstuff_next_q, unstuff_next_d;
  logic        chain_active_q, chain_active_d;
  logic        timer_armed_q, timer_armed_d;
  logic [31:0] start_time_q, start_time_d;
  logic [7:0]  last_id_q, last_id_d;
  logic [7:0]  valid_len_q, valid_len_d;
  status_e     status_d;

  // Result register.
  logic        out_valid_q;
  status_e     status_q;
  logic [7:0]  good_id_q;
  logic [7:0]  packet_len_q;
  logic        rd_sel_q;

  logic        in_fire;
  logic [31:0] limit;
  logic        stale;
  logic [8:0]  chain_sum;
  logic        ram_we;
  logic [7:0]  ram_wdata;
  logic        ram_re;
  logic [7:0]  ram_rdata;
  logic        rd_in_range;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign limit       = (timeout_q == '0) ? TIMEOUT_RESET : timeout_q;
  assign stale       = timer_armed_q && ((now_ms_i - start_time_q) >= limit);
  assign chain_sum   = {1'b0, byte_count_q} + {1'b0, data_byte_i};
  assign rd_in_range = read_index_i < MaxPay8;
  assign ram_re      = in_fire && req_type_i && rd_in_range;

  always_comb begin
    phase_d        = phase_q;
    frame_id_d     = frame_id_q;
    expected_len_d = expected_len_q;
    byte_count_d   = byte_count_q;
    crc_d          = crc_q;
    unstuff_next_d = unstuff_next_q;
    chain_active_d = chain_active_q;
    timer_armed_d  = timer_armed_q;
    start_time_d   = start_time_q;
    last_id_d      = last_id_q;
    valid_len_d    = valid_len_q;
    status_d       = ST_CONTINUE;
    ram_we         = 1'b0;
    ram_wdata      = data_byte_i;

    if (in_fire && !req_type_i) begin
      valid_len_d = '0;
      if (stale) begin
        // Drop the byte and abandon the frame.
        phase_d       = PH_START;
        timer_armed_d = 1'b0;
        status_d      = ST_STALE;
      end else begin
        unique case (phase_q)
          PH_START: begin
            if (data_byte_i == start_byte_q) begin
              phase_d       = PH_ID;
              timer_armed_d = 1'b1;
              start_time_d  = now_ms_i;
            end
          end
          PH_ID: begin
            frame_id_d = data_byte_i;
            phase_d    = PH_OVERHEAD;
          end
          PH_OVERHEAD: begin
            unstuff_next_d = data_byte_i;
            chain_active_d = data_byte_i < MaxPay8;
            phase_d        = PH_LEN;
          end
          PH_LEN: begin
            if (data_byte_i == '0 || data_byte_i > MaxPay8) begin
              phase_d       = PH_START;
              timer_armed_d = 1'b0;
              status_d      = ST_LEN_ERR;
            end else begin
              expected_len_d = data_byte_i;
              byte_count_d   = '0;
              crc_d          = '0;
              phase_d        = PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            if (byte_count_q < MaxPay8) begin
              crc_d = crc8_update(crc_q, data_byte_i);
              if (chain_active_q && byte_count_q == unstuff_next_q) begin
                // Restore the start byte; advance or end the chain.
                ram_wdata = start_byte_q;
                if (data_byte_i == '0 || chain_sum >= MaxPay9) begin
                  chain_active_d = 1'b0;
                end else begin
                  unstuff_next_d = chain_sum[7:0];
                end
              end
              ram_we       = 1'b1;
              byte_count_d = byte_count_q + 8'd1;
            end
            if (byte_count_d >= expected_len_q || byte_count_d >= MaxPay8) begin
              phase_d = PH_CRC;
            end
          end
          PH_CRC: begin
            if (data_byte_i != crc_q) begin
              phase_d       = PH_START;
              timer_armed_d = 1'b0;
              status_d      = ST_CRC_ERR;
            end else begin
              phase_d = PH_STOP;
            end
          end
          PH_STOP: begin
            phase_d       = PH_START;
            timer_armed_d = 1'b0;
            if (data_byte_i == stop_byte_q) begin
              valid_len_d = expected_len_q;
              last_id_d   = frame_id_q;
              status_d    = ST_NEW;
            end else begin
              status_d = ST_STOP_ERR;
            end
          end
          default: phase_d = PH_START;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_START;
      frame_id_q     <= '0;
      expected_len_q <= '0;
      byte_count_q   <= '0;
      crc_q          <= '0;
      unstuff_next_q <= '0;
      chain_active_q <= 1'b0;
      timer_armed_q  <= 1'b0;
      start_time_q   <= '0;
      last_id_q      <= '0;
      valid_len_q    <= '0;
      out_valid_q    <= 1'b0;
      status_q       <= ST_CONTINUE;
      good_id_q      <= '0;
      packet_len_q   <= '0;
      rd_sel_q       <= 1'b0;
    end else begin
      phase_q        <= phase_d;
      frame_id_q     <= frame_id_d;
      expected_len_q <= expected_len_d;
      byte_count_q   <= byte_count_d;
      crc_q          <= crc_d;
      unstuff_next_q <= unstuff_next_d;
      chain_active_q <= chain_active_d;
      timer_armed_q  <= timer_armed_d;
      start_time_q   <= start_time_d;
      last_id_q      <= last_id_d;
      valid_len_q    <= valid_len_d;
      if (in_fire) begin
        out_valid_q  <= 1'b1;
        status_q     <= status_d;
        good_id_q    <= last_id_d;
        packet_len_q <= valid_len_d;
        rd_sel_q     <= req_type_i && rd_in_range;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  fpr_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PAYLOAD)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (byte_count_q[AW-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (read_index_i[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign good_id_o    = good_id_q;
  assign packet_len_o = packet_len_q;
  assign read_data_o  = rd_sel_q ? ram_rdata : '0;

endmodule

// ===== design/fpr_checker.sv =====
// Port-level checker for the framed packet receiver, bound to the top level.
// Depends on fpr_pkg and framed_packet_receiver_assert.svh.
`include "framed_packet_receiver_assert.svh"

module fpr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               req_type_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input fpr_pkg::status_e   status_o,
  input logic [7:0]         good_id_o,
  input logic [7:0]         packet_len_o,
  input logic [7:0]         read_data_o
);
  import fpr_pkg::*;

  // Hold a stalled result beat.
  `FPR_ASSERT(a_out_hold, clk_i, rst_ni,
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
      $stable(good_id_o) && $stable(packet_len_o) && $stable(read_data_o),
    "result beat changed while stalled")

  // A read beat reports continue.
  `FPR_ASSERT(a_read_status, clk_i, rst_ni,
    in_valid_i && in_ready_o && req_type_i |=> out_valid_o && status_o == ST_CONTINUE,
    "read beat gave a non-continue status")

  // A line beat shows a length exactly when it completes a good packet.
  `FPR_ASSERT(a_len_new, clk_i, rst_ni,
    in_valid_i && in_ready_o && !req_type_i |=>
      out_valid_o && ((status_o == ST_NEW) == (packet_len_o != 8'd0)),
    "packet length and new-packet status disagree")

  `FPR_ASSERT_ALWAYS(a_reset_idle, clk_i,
    !rst_ni |=> !out_valid_o,
    "result valid after reset")

endmodule

bind framed_packet_receiver fpr_checker u_fpr_checker (.*);

// ===== dv/tb_framed_packet_receiver.sv =====
// Self-checking testbench for framed_packet_receiver: framed line bytes and store reads
// go in over valid/ready, each result beat is checked against an in-bench frame parser.
// Depends on fpr_pkg (status codes, register indexes) and the receiver RTL.
module tb_framed_packet_receiver;
  timeunit 1ns;
  timeprecision 1ps;

  import fpr_pkg::*;

  localparam int          PAYLOAD_MAX     = 254;
  localparam logic [31:0] ZERO_TIMEOUT_MS = 32'd50;
  localparam int          HOLD_CYCLES     = 64;
  localparam int          STALL_LIMIT     = 1000;

  typedef enum logic [2:0] {
    P_SEEK, P_ID, P_OVH, P_LEN, P_PAY, P_CRC, P_STOP
  } rx_phase_e;

  typedef enum int {
    FR_GOOD, FR_BAD_LEN, FR_BAD_CRC, FR_BAD_STOP, FR_STALE
  } frame_kind_e;

  typedef struct packed {
    status_e    status;
    logic [7:0] id;
    logic [7:0] len;
    logic [7:0] rdata;
  } rx_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        req_type = 1'b0;
  logic [7:0]  data_byte = 8'h00;
  logic [31:0] now_ms = 32'h0;
  logic [7:0]  read_index = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  status_e     status;
  logic [7:0]  good_id;
  logic [7:0]  packet_len;
  logic [7:0]  read_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'h0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  framed_packet_receiver u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .req_type_i   (req_type),
    .data_byte_i  (data_byte),
    .now_ms_i     (now_ms),
    .read_index_i (read_index),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .status_o     (status),
    .good_id_o    (good_id),
    .packet_len_o (packet_len),
    .read_data_o  (read_data),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Parser copy: configuration and frame state
  logic [31:0] cfg_timeout = 32'd50;
  logic [7:0]  cfg_start   = 8'd126;
  logic [7:0]  cfg_stop    = 8'd129;
  rx_phase_e   rx_phase    = P_SEEK;
  logic [7:0]  cur_id      = 8'h00;
  logic [7:0]  want_len    = 8'h00;
  logic [7:0]  got_cnt     = 8'h00;
  logic [7:0]  crc_acc     = 8'h00;
  logic [7:0]  chain_pos   = 8'h00;
  logic        chain_on    = 1'b0;
  logic        armed       = 1'b0;
  logic [31:0] t_start     = 32'h0;
  logic [7:0]  pub_id      = 8'h00;
  logic [7:0]  pub_len     = 8'h00;
  logic [7:0]  rx_store [0:PAYLOAD_MAX-1];
  int          store_fill  = 0;  // store is written as a prefix from index 0

  rx_result_t  pending_results[$];
  rx_result_t  head_result;
  int          mismatch_cnt = 0;
  int          results_seen = 0;
  int          beats_sent = 0;
  int          idle_cycles = 0;
  bit          no_idle = 1'b0;
  int          holds_asked = 0;
  int          holds_served = 0;
  int          hold_left = 0;
  logic [31:0] clk_ms = 32'h0;

  function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    repeat (8) begin
      if (c[7]) c = {c[6:0], 1'b0} ^ 8'h9B;
      else      c = {c[6:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [31:0] stale_after();
    return (cfg_timeout == 32'h0) ? ZERO_TIMEOUT_MS : cfg_timeout;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at result %0d, %s: got 0x%0h, want 0x%0h",
             results_seen, what, got, want);
    mismatch_cnt++;
  endtask

  // Advance the parser copy by one accepted beat and queue its result.
  task automatic predict_beat(input logic req, input logic [7:0] b, input logic [31:0] now,
                              input logic [7:0] idx);
    rx_result_t  r;
    logic [8:0]  nxt;
    logic [7:0]  keep;
    r = '0;
    r.status = ST_CONTINUE;
    if (req) begin
      if (idx < PAYLOAD_MAX) r.rdata = rx_store[idx];
    end else begin
      pub_len = 8'h00;
      if (armed && (now - t_start) >= stale_after()) begin
        rx_phase = P_SEEK;
        armed = 1'b0;
        r.status = ST_STALE;
      end else begin
        case (rx_phase)
          P_SEEK: begin
            if (b == cfg_start) begin
              rx_phase = P_ID;
              armed = 1'b1;
              t_start = now;
            end
          end
          P_ID: begin
            cur_id = b;
            rx_phase = P_OVH;
          end
          P_OVH: begin
            chain_pos = b;
            chain_on = (b < PAYLOAD_MAX);
            rx_phase = P_LEN;
          end
          P_LEN: begin
            if (b == 8'h00 || b > PAYLOAD_MAX) begin
              rx_phase = P_SEEK;
              armed = 1'b0;
              r.status = ST_LEN_ERR;
            end else begin
              want_len = b;
              got_cnt = 8'h00;
              crc_acc = 8'h00;
              rx_phase = P_PAY;
            end
          end
          P_PAY: begin
            if (got_cnt < PAYLOAD_MAX) begin
              keep = b;
              crc_acc = crc8_step(crc_acc, b);
              // chain position: restore the start byte, follow or end the chain
              if (chain_on && got_cnt == chain_pos) begin
                nxt = got_cnt + b;
                keep = cfg_start;
                if (b == 8'h00 || nxt >= PAYLOAD_MAX) chain_on = 1'b0;
                else chain_pos = nxt[7:0];
              end
              rx_store[got_cnt] = keep;
              got_cnt = got_cnt + 8'd1;
              if (got_cnt > store_fill) store_fill = got_cnt;
            end
            if (got_cnt >= want_len || got_cnt >= PAYLOAD_MAX) rx_phase = P_CRC;
          end
          P_CRC: begin
            if (b != crc_acc) begin
              rx_phase = P_SEEK;
              armed = 1'b0;
              r.status = ST_CRC_ERR;
            end else begin
              rx_phase = P_STOP;
            end
          end
          P_STOP: begin
            rx_phase = P_SEEK;
            armed = 1'b0;
            if (b == cfg_stop) begin
              pub_len = want_len;
              pub_id = cur_id;
              r.status = ST_NEW;
            end else begin
              r.status = ST_STOP_ERR;
            end
          end
          default: rx_phase = P_SEEK;
        endcase
      end
    end
    r.id = pub_id;
    r.len = pub_len;
    pending_results.push_back(r);
  endtask

  task automatic send_beat(input logic req, input logic [7:0] b, input logic [31:0] now,
                           input logic [7:0] idx);
    int gap;
    in_valid <= 1'b1;
    req_type <= req;
    data_byte <= b;
    now_ms <= now;
    read_index <= idx;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    beats_sent++;
    predict_beat(req, b, now, idx);
    if (!no_idle && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 3);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_line(input logic [7:0] b);
    send_beat(1'b0, b, clk_ms, 8'($urandom_range(253)));
  endtask

  task automatic read_at(input logic [7:0] idx);
    send_beat(1'b1, 8'($urandom_range(255)), $urandom(), idx);
  endtask

  // Only read entries that some frame has written.
  task automatic read_random();
    if (store_fill > 0) read_at(8'($urandom_range(store_fill - 1)));
    else send_line(8'($urandom_range(255)));
  endtask

  task automatic finish_phase();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] val);
    logic [31:0] mask;
    mask = (idx == REG_TIMEOUT) ? 32'hFFFF_FFFF : 32'h0000_00FF;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_TIMEOUT: cfg_timeout = val;
      REG_START:   cfg_start = val[7:0];
      REG_STOP:    cfg_stop = val[7:0];
      default: ;
    endcase
    // read the register back
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if ((prdata & mask) != (val & mask))
      report_mismatch("register readback", prdata & mask, val & mask);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Send one frame of the given kind; len_req of 0 picks a random small length.
  task automatic send_frame(input frame_kind_e kind, input int len_req);
    logic [7:0] body[$];
    logic [7:0] crc;
    logic [7:0] b;
    int         len;
    int         cut;
    bit         hold_time;
    // drop a frame left half done by stepping the clock to its timeout
    if (armed) begin
      clk_ms = t_start + stale_after();
      send_line(8'($urandom_range(255)));
    end
    if ($urandom_range(7) == 0) clk_ms = clk_ms + $urandom();
    if (len_req > 0) len = len_req;
    else if ($urandom_range(9) == 0) len = $urandom_range(13, 60);
    else len = $urandom_range(1, 12);
    body.push_back(cfg_start);
    body.push_back(8'($urandom_range(255)));
    case ($urandom_range(3))
      0, 1:    body.push_back(8'($urandom_range(len - 1)));
      2:       body.push_back(8'($urandom_range(254, 255)));
      default: body.push_back(8'($urandom_range(255)));
    endcase
    if (kind == FR_BAD_LEN) begin
      body.push_back($urandom_range(1) ? 8'd0 : 8'd255);
    end else begin
      body.push_back(8'(len));
      crc = 8'h00;
      for (int i = 0; i < len; i++) begin
        b = ($urandom_range(9) < 3) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
        crc = crc8_step(crc, b);
        body.push_back(b);
      end
      if (kind == FR_BAD_CRC) crc = crc ^ 8'($urandom_range(1, 255));
      body.push_back(crc);
      if (kind == FR_BAD_STOP) body.push_back(cfg_stop ^ 8'($urandom_range(1, 255)));
      else body.push_back(cfg_stop);
    end
    cut = $urandom_range(1, body.size() - 1);
    hold_time = $urandom_range(1);
    for (int i = 0; i < body.size(); i++) begin
      if ($urandom_range(9) == 0) read_random();
      if (kind == FR_STALE && i == cut) begin
        clk_ms = t_start + stale_after();
        send_line(body[i]);
        break;
      end
      if (!hold_time && $urandom_range(3) == 0) clk_ms = clk_ms + $urandom_range(1, 3);
      send_line(body[i]);
    end
  endtask

  task automatic test_directed();
    // good frame, zero byte at the first chain position ends the chain
    send_line(cfg_start);
    send_line(8'hFF);
    send_line(8'h00);
    send_line(8'd1);
    send_line(8'h00);
    send_line(crc8_step(8'h00, 8'h00));
    send_line(cfg_stop);
    read_at(8'd0);
    // length zero, no chain
    send_line(cfg_start);
    send_line(8'h00);
    send_line(8'hFE);
    send_line(8'd0);
    // length above the maximum
    send_line(cfg_start);
    send_line(8'h01);
    send_line(8'hFF);
    send_line(8'hFF);
    // CRC mismatch, chain step past the end, read in the middle of the frame
    send_line(cfg_start);
    send_line(8'h5A);
    send_line(8'h00);
    send_line(8'd2);
    send_line(8'h01);
    read_at(8'd0);
    send_line(8'hFF);
    send_line(~crc8_step(crc8_step(8'h00, 8'h01), 8'hFF));
    // wrong stop byte
    send_line(cfg_start);
    send_line(8'h33);
    send_line(8'hFE);
    send_line(8'd1);
    send_line(8'h80);
    send_line(crc8_step(8'h00, 8'h80));
    send_line(~cfg_stop);
    // stale frame at exactly the timeout
    send_line(cfg_start);
    clk_ms = clk_ms + stale_after();
    send_line(8'h12);
    // index past the store
    read_at(8'd254);
    finish_phase();
  endtask

  task automatic test_max_frame();
    write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
    write_reg(REG_START, 32'h0000_0000);
    write_reg(REG_STOP, 32'h0000_00FF);
    send_frame(FR_GOOD, PAYLOAD_MAX);
    read_at(8'd0);
    read_at(8'd253);
    read_at(8'($urandom_range(253)));
    // one millisecond short of the longest timeout, then exactly on it
    send_line(cfg_start);
    clk_ms = t_start + 32'hFFFF_FFFE;
    send_line(8'($urandom_range(255)));
    clk_ms = t_start + 32'hFFFF_FFFF;
    send_line(8'($urandom_range(255)));
    finish_phase();
  endtask

  task automatic test_random_traffic();
    int r;
    int stop_at;
    for (int seg = 0; seg < 5; seg++) begin
      case (seg)
        0: begin
          write_reg(REG_TIMEOUT, 32'h0);
          write_reg(REG_START, 32'd126);
          write_reg(REG_STOP, 32'd129);
        end
        1: begin
          write_reg(REG_TIMEOUT, 32'd1);
          write_reg(REG_START, 32'hFF);
          write_reg(REG_STOP, 32'h00);
        end
        2: begin
          write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
          write_reg(REG_START, 32'h00);
          write_reg(REG_STOP, 32'hFF);
        end
        3: begin
          write_reg(REG_TIMEOUT, $urandom_range(2, 200));
          write_reg(REG_START, $urandom_range(255));
          write_reg(REG_STOP, $urandom_range(255));
        end
        default: begin
          write_reg(REG_TIMEOUT, 32'd50);
          write_reg(REG_START, 32'd126);
          write_reg(REG_STOP, 32'd129);
        end
      endcase
      no_idle = (seg == 3);
      stop_at = beats_sent + 40;
      while (beats_sent < stop_at) begin
        r = $urandom_range(99);
        if (r < 55) send_frame(FR_GOOD, 0);
        else if (r < 75) send_frame(frame_kind_e'($urandom_range(FR_BAD_LEN, FR_STALE)), 0);
        else if (r < 88) read_random();
        else begin
          clk_ms = clk_ms + $urandom_range(0, 2);
          send_line(8'($urandom_range(255)));
        end
      end
      finish_phase();
    end
    no_idle = 1'b0;
  endtask

  task automatic test_backpressure();
    no_idle = 1'b1;
    holds_asked++;
    send_frame(FR_GOOD, 20);
    repeat (10) read_random();
    send_frame(FR_GOOD, 0);
    finish_phase();
    no_idle = 1'b0;
  endtask

  // Result side: random stalls, plus long hold-offs on request
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      holds_served <= holds_served + 1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (no_idle) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 20);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", 32'(status), 32'h0);
      end else begin
        head_result = pending_results.pop_front();
        if (status != head_result.status)
          report_mismatch("status", 32'(status), 32'(head_result.status));
        if (good_id != head_result.id)
          report_mismatch("good_id", 32'(good_id), 32'(head_result.id));
        if (packet_len != head_result.len)
          report_mismatch("packet_len", 32'(packet_len), 32'(head_result.len));
        if (read_data != head_result.rdata)
          report_mismatch("read_data", 32'(read_data), 32'(head_result.rdata));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb_framed_packet_receiver NOT OK");
        $finish;
      end
    end
  end

  initial begin
    clk_ms = $urandom();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_max_frame();
    test_random_traffic();
    test_backpressure();
    repeat (4) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("tb_framed_packet_receiver OK");
    end else begin
      $display("tb_framed_packet_receiver NOT OK");
    end
    $finish;
  end

endmodule
